### src/afar_pkg.sv
// Package for the aspect fit and align block: coordinate width default,
// alignment codes and the code that marks which size the divider fills in.
// No dependencies.
package afar_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Alignment codes, shared by both axes
    localparam logic [1:0] ALIGN_CENTER = 2'd0;
    localparam logic [1:0] ALIGN_NEAR   = 2'd1;
    localparam logic [1:0] ALIGN_FAR    = 2'd2;
    localparam logic [1:0] ALIGN_KEEP   = 2'd3;

    // Which placed size takes the divider quotient
    typedef enum logic [1:0] {
        DST_NONE = 2'd0,
        DST_W    = 2'd1,
        DST_H    = 2'd2
    } t_dst;

endpackage

### src/afar_in_if.sv
// Input channel of the aspect fit block: valid/ready plus one source and
// container rectangle with alignment codes. Depends on afar_pkg.
interface afar_in_if import afar_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] src_x;
    logic [COORD_BITS-1:0] src_y;
    logic [COORD_BITS-1:0] src_w;
    logic [COORD_BITS-1:0] src_h;
    logic [COORD_BITS-1:0] cont_x;
    logic [COORD_BITS-1:0] cont_y;
    logic [COORD_BITS-1:0] cont_w;
    logic [COORD_BITS-1:0] cont_h;
    logic [1:0]            horz_align;
    logic [1:0]            vert_align;
    logic                  keep_size;

    modport source (
        output valid, src_x, src_y, src_w, src_h, cont_x, cont_y, cont_w, cont_h,
               horz_align, vert_align, keep_size,
        input  ready
    );

    modport sink (
        input  valid, src_x, src_y, src_w, src_h, cont_x, cont_y, cont_w, cont_h,
               horz_align, vert_align, keep_size,
        output ready
    );
endinterface

### src/afar_out_if.sv
// Output channel of the aspect fit block: valid/ready plus the placed
// rectangle and its status flags. Depends on afar_pkg.
interface afar_out_if import afar_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] fit_x;
    logic [COORD_BITS-1:0] fit_y;
    logic [COORD_BITS-1:0] fit_w;
    logic [COORD_BITS-1:0] fit_h;
    logic                  overhang;
    logic                  bad_size;

    modport source (
        output valid, fit_x, fit_y, fit_w, fit_h, overhang, bad_size,
        input  ready
    );

    modport sink (
        input  valid, fit_x, fit_y, fit_w, fit_h, overhang, bad_size,
        output ready
    );
endinterface

### src/afar_prep.sv
// Front end of the aspect fit block: cross products, ratio compare and
// divider setup over two register stages. Depends on afar_pkg, afar_in_if.
module afar_prep import afar_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    afar_in_if.sink                   i_rect,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2*COORD_BITS-1:0]   o_acc,
    output logic [COORD_BITS-1:0]     o_dvsr,
    output logic [8*COORD_BITS+6:0]   o_side
);
    localparam int N = COORD_BITS;

    typedef struct packed {
        logic [N-1:0] fx;
        logic [N-1:0] fy;
        logic [N-1:0] fw;
        logic [N-1:0] fh;
        logic [N-1:0] cx;
        logic [N-1:0] cy;
        logic [N-1:0] cw;
        logic [N-1:0] ch;
        logic [1:0]   ha;
        logic [1:0]   va;
        logic         bad;
        t_dst         dst;
    } t_side;

    // Stage A: registered inputs and the two cross products
    logic           r_a_valid;
    logic [N-1:0]   r_sx, r_sy, r_sw, r_sh, r_cx, r_cy, r_cw, r_ch;
    logic [1:0]     r_ha, r_va;
    logic           r_keep;
    logic [2*N-1:0] r_p_sc;   // src_w * cont_h
    logic [2*N-1:0] r_p_cs;   // cont_w * src_h

    // Stage B: divider operands and carried fields
    logic           r_b_valid;
    logic [2*N-1:0] r_acc;
    logic [N-1:0]   r_dvsr;
    t_side          r_side;

    logic           w_ready_a;
    logic           w_ready_b;
    logic           w_take_a;
    logic           w_take_b;
    logic [2*N-1:0] n_acc;
    logic [N-1:0]   n_dvsr;
    t_side          n_side;

    assign w_ready_b    = !r_b_valid || i_ready;
    assign w_ready_a    = !r_a_valid || w_ready_b;
    assign i_rect.ready = w_ready_a;
    assign w_take_a     = i_rect.valid && w_ready_a;
    assign w_take_b     = r_a_valid && w_ready_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_a_valid <= i_rect.valid;
            end
            if (w_ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_a) begin
            r_sx   <= i_rect.src_x;
            r_sy   <= i_rect.src_y;
            r_sw   <= i_rect.src_w;
            r_sh   <= i_rect.src_h;
            r_cx   <= i_rect.cont_x;
            r_cy   <= i_rect.cont_y;
            r_cw   <= i_rect.cont_w;
            r_ch   <= i_rect.cont_h;
            r_ha   <= i_rect.horz_align;
            r_va   <= i_rect.vert_align;
            r_keep <= i_rect.keep_size;
            r_p_sc <= {{N{1'b0}}, i_rect.src_w} * {{N{1'b0}}, i_rect.cont_h};
            r_p_cs <= {{N{1'b0}}, i_rect.cont_w} * {{N{1'b0}}, i_rect.src_h};
        end
        if (w_take_b) begin
            r_acc  <= n_acc;
            r_dvsr <= n_dvsr;
            r_side <= n_side;
        end
    end

    // Pick fit to width or height; a used quotient always fits the coordinate width
    always_comb begin
        n_side.fx  = r_sx;
        n_side.fy  = r_sy;
        n_side.fw  = r_sw;
        n_side.fh  = r_sh;
        n_side.cx  = r_cx;
        n_side.cy  = r_cy;
        n_side.cw  = r_cw;
        n_side.ch  = r_ch;
        n_side.ha  = r_ha;
        n_side.va  = r_va;
        n_side.bad = !r_keep && ((r_sw == '0) || (r_sh == '0));
        n_side.dst = DST_NONE;
        n_acc      = r_p_sc;
        n_dvsr     = r_sh;
        if (!r_keep && !n_side.bad) begin
            if (r_p_sc > r_p_cs) begin
                n_side.fx  = r_cx;
                n_side.fw  = r_cw;
                n_side.dst = DST_H;
                n_acc      = r_p_cs;
                n_dvsr     = r_sw;
            end else begin
                n_side.fy  = r_cy;
                n_side.fh  = r_ch;
                n_side.dst = DST_W;
            end
        end
    end

    assign o_valid = r_b_valid;
    assign o_acc   = r_acc;
    assign o_dvsr  = r_dvsr;
    assign o_side  = r_side;

endmodule

### src/afar_div_cell.sv
// One cell of the divider chain: a restoring divide step that yields one
// quotient bit and hands the item to the next cell. Depends on afar_pkg.
module afar_div_cell import afar_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SIDE_W     = 8 * COORD_BITS + 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2*COORD_BITS-1:0] i_acc,
    input  logic [COORD_BITS-1:0]   i_dvsr,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [2*COORD_BITS-1:0] o_acc,
    output logic [COORD_BITS-1:0]   o_dvsr,
    output logic [SIDE_W-1:0]       o_side
);
    localparam int N = COORD_BITS;

    logic           r_valid;
    logic [2*N-1:0] r_acc;
    logic [N-1:0]   r_dvsr;
    logic [SIDE_W-1:0] r_side;

    logic [N:0]     w_top;
    logic [N:0]     w_diff;
    logic           w_ge;
    logic [2*N-1:0] n_acc;

    // Remainder sits in the upper half, quotient bits shift in at the bottom
    assign w_top  = i_acc[2*N-1:N-1];
    assign w_diff = w_top - {1'b0, i_dvsr};
    assign w_ge   = !w_diff[N];
    assign n_acc  = {(w_ge ? w_diff[N-1:0] : w_top[N-1:0]), i_acc[N-2:0], w_ge};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_acc  <= n_acc;
            r_dvsr <= i_dvsr;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_dvsr  = r_dvsr;
    assign o_side  = r_side;

endmodule

### src/afar_place.sv
// Back end of the aspect fit block: merge the quotient, clamp spare space,
// align both edges and hold the result item. Depends on afar_pkg, afar_out_if.
module afar_place import afar_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2*COORD_BITS-1:0] i_acc,
    input  logic [8*COORD_BITS+6:0] i_side,
    afar_out_if.source              o_fit
);
    localparam int N = COORD_BITS;

    typedef struct packed {
        logic [N-1:0] fx;
        logic [N-1:0] fy;
        logic [N-1:0] fw;
        logic [N-1:0] fh;
        logic [N-1:0] cx;
        logic [N-1:0] cy;
        logic [N-1:0] cw;
        logic [N-1:0] ch;
        logic [1:0]   ha;
        logic [1:0]   va;
        logic         bad;
        t_dst         dst;
    } t_side;

    t_side        w_side;
    logic [N-1:0] w_quo;
    logic [N-1:0] w_fw, w_fh;
    logic [N:0]   w_dh, w_dv;
    logic [N-1:0] w_hs, w_vs;
    logic [N-1:0] n_x, n_y;

    logic         r_valid;
    logic [N-1:0] r_x, r_y, r_w, r_h;
    logic         r_over, r_bad;

    assign w_side = i_side;
    assign w_quo  = i_acc[N-1:0];

    always_comb begin
        w_fw = w_side.fw;
        w_fh = w_side.fh;
        case (w_side.dst)
            DST_W:   w_fw = w_quo;
            DST_H:   w_fh = w_quo;
            default: ;
        endcase
    end

    // Spare space, clamped to zero when the placed size overhangs
    assign w_dh = {1'b0, w_side.cw} - {1'b0, w_fw};
    assign w_dv = {1'b0, w_side.ch} - {1'b0, w_fh};
    assign w_hs = w_dh[N] ? '0 : w_dh[N-1:0];
    assign w_vs = w_dv[N] ? '0 : w_dv[N-1:0];

    always_comb begin
        unique case (w_side.ha)
            ALIGN_CENTER: n_x = w_side.cx + (w_hs >> 1);
            ALIGN_NEAR:   n_x = w_side.cx;
            ALIGN_FAR:    n_x = w_side.cx + w_hs;
            default:      n_x = w_side.fx;
        endcase
        unique case (w_side.va)
            ALIGN_CENTER: n_y = w_side.cy + (w_vs >> 1);
            ALIGN_NEAR:   n_y = w_side.cy;
            ALIGN_FAR:    n_y = w_side.cy + w_vs;
            default:      n_y = w_side.fy;
        endcase
    end

    assign o_ready = !r_valid || o_fit.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_w    <= w_fw;
            r_h    <= w_fh;
            r_over <= w_dh[N] || w_dv[N];
            r_bad  <= w_side.bad;
        end
    end

    assign o_fit.valid    = r_valid;
    assign o_fit.fit_x    = r_x;
    assign o_fit.fit_y    = r_y;
    assign o_fit.fit_w    = r_w;
    assign o_fit.fit_h    = r_h;
    assign o_fit.overhang = r_over;
    assign o_fit.bad_size = r_bad;

endmodule

### src/aspect_fit_align_rect.sv
// Aspect fit and align: places a source rectangle inside a container.
// Top level; depends on afar_pkg, afar_in_if, afar_out_if, afar_prep,
// afar_div_cell and afar_place.
//
// Usage:
//   i_rect carries one item per handshake (valid && ready): source and
//   container rectangles, horizontal and vertical alignment codes and the
//   keep-size flag. o_fit returns exactly one item per input item, in order:
//   the placed rectangle plus overhang and bad_size flags.
//   An item passes through COORD_BITS + 3 register stages (19 at the default
//   width) before it can be taken from o_fit: two front-end stages for the
//   cross products and ratio compare, one divider cell per quotient bit,
//   and the output register.
//   Throughput is one item per cycle while o_fit is not stalled; the divider chain
//   produces one quotient bit per cell, so every cell holds a different item.
//   Every stage has its own valid bit and takes a new item when it is empty
//   or its neighbor is taking its current one, so bubbles squeeze out and a
//   stalled receiver only stops the chain once every stage is full;
//   i_rect.ready then drops in the same cycle.
//   A synchronous reset (i_rst_n low) empties all stages; results of items
//   in flight are dropped. There are no configuration registers.
module aspect_fit_align_rect import afar_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    afar_in_if.sink     i_rect,
    afar_out_if.source  o_fit
);
    localparam int N      = COORD_BITS;
    localparam int SIDE_W = 8 * COORD_BITS + 7;

    // Chain index k is the link into divider cell k; index N feeds placement
    logic [N:0]        w_valid;
    logic [N:0]        w_ready;
    logic [2*N-1:0]    w_acc  [N+1];
    logic [N-1:0]      w_dvsr [N+1];
    logic [SIDE_W-1:0] w_side [N+1];

    afar_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rect  (i_rect),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_acc   (w_acc[0]),
        .o_dvsr  (w_dvsr[0]),
        .o_side  (w_side[0])
    );

    // Divider chain: one cell per quotient bit, most significant first
    for (genvar k = 0; k < N; k++) begin : g_cell
        afar_div_cell #(
            .COORD_BITS (COORD_BITS),
            .SIDE_W     (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_acc   (w_acc[k]),
            .i_dvsr  (w_dvsr[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_acc   (w_acc[k+1]),
            .o_dvsr  (w_dvsr[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // Merge quotient, clamp, align, and hold the result item for o_fit
    afar_place #(
        .COORD_BITS (COORD_BITS)
    ) u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[N]),
        .o_ready (w_ready[N]),
        .i_acc   (w_acc[N]),
        .i_side  (w_side[N]),
        .o_fit   (o_fit)
    );

endmodule

### dv/tb.sv
// Testbench for aspect_fit_align_rect: directed and random rectangles checked
// against a built-in letterbox fit and alignment predictor.
// Depends on afar_pkg, afar_in_if, afar_out_if and the block's sources.
`timescale 1ns / 100ps

module tb import afar_pkg::*; ();

    localparam int CB        = COORD_BITS_DEF;
    localparam int LATENCY   = CB + 3;
    localparam int LIMIT     = 200000;
    localparam int RAND_ITEMS = 412;

    typedef struct packed {
        logic [CB-1:0] src_x;
        logic [CB-1:0] src_y;
        logic [CB-1:0] src_w;
        logic [CB-1:0] src_h;
        logic [CB-1:0] cont_x;
        logic [CB-1:0] cont_y;
        logic [CB-1:0] cont_w;
        logic [CB-1:0] cont_h;
        logic [1:0]    horz_align;
        logic [1:0]    vert_align;
        logic          keep_size;
    } t_rect;

    typedef struct packed {
        logic [CB-1:0] fit_x;
        logic [CB-1:0] fit_y;
        logic [CB-1:0] fit_w;
        logic [CB-1:0] fit_h;
        logic          overhang;
        logic          bad_size;
    } t_fit;

    logic i_clk;
    logic i_rst_n;

    afar_in_if  #(.COORD_BITS(CB)) rect_if ();
    afar_out_if #(.COORD_BITS(CB)) fit_if ();

    aspect_fit_align_rect #(.COORD_BITS(CB)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rect  (rect_if.sink),
        .o_fit   (fit_if.source)
    );

    // Placed rectangles predicted for accepted items, oldest first
    t_fit fit_expected[$];
    int   mismatch_count;
    int   cycle_count;
    // Idle odds in percent for the sender and the receiver
    int   src_idle_pct;
    int   snk_stall_pct;

    logic [1:0] align_codes[4] = '{ALIGN_CENTER, ALIGN_NEAR, ALIGN_FAR, ALIGN_KEEP};

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run: count edges and give up past the limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: letterbox fit by exact cross-multiplied ratio compare,
    // truncating division for the free side, then per-axis alignment.
    // ------------------------------------------------------------------

    // Spare room on one axis; clamp to zero and flag overhang when the
    // placed size does not fit.
    function automatic logic [63:0] clamp_spare(input logic [63:0] span,
                                                input logic [63:0] size,
                                                inout bit over);
        if (size > span) begin
            over = 1'b1;
            return 64'd0;
        end
        return span - size;
    endfunction

    // Edge position for one alignment code; the sum wraps at the coordinate width.
    function automatic logic [CB-1:0] align_edge(input logic [1:0] code,
                                                 input logic [63:0] keep_edge,
                                                 input logic [63:0] base,
                                                 input logic [63:0] space);
        logic [63:0] pos;
        case (code)
            ALIGN_CENTER: pos = base + (space >> 1);
            ALIGN_NEAR:   pos = base;
            ALIGN_FAR:    pos = base + space;
            default:      pos = keep_edge;
        endcase
        return pos[CB-1:0];
    endfunction

    function automatic t_fit predict_fit(input t_rect r);
        t_fit        f;
        logic [63:0] sw, sh, cw, ch, fx, fy, fw, fh, vs, hs;
        bit          over;
        sw = 64'(r.src_w);
        sh = 64'(r.src_h);
        cw = 64'(r.cont_w);
        ch = 64'(r.cont_h);
        fx = 64'(r.src_x);
        fy = 64'(r.src_y);
        fw = sw;
        fh = sh;
        over = 1'b0;
        f.bad_size = 1'b0;
        if (!r.keep_size) begin
            if (sw == 0 || sh == 0) begin
                // Nothing to scale: pass the size through and flag it
                f.bad_size = 1'b1;
            end else if (sw * ch > cw * sh) begin
                // Wider than the container: fill its width
                fx = 64'(r.cont_x);
                fw = cw;
                fh = (cw * sh) / sw;
            end else begin
                // Otherwise fill the height; ties and zero container height land here
                fy = 64'(r.cont_y);
                fh = ch;
                fw = (ch * sw) / sh;
            end
        end
        vs = clamp_spare(ch, fh, over);
        hs = clamp_spare(cw, fw, over);
        f.fit_y    = align_edge(r.vert_align, fy, 64'(r.cont_y), vs);
        f.fit_x    = align_edge(r.horz_align, fx, 64'(r.cont_x), hs);
        f.fit_w    = fw[CB-1:0];
        f.fit_h    = fh[CB-1:0];
        f.overhang = over;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional idle gap, then hold the item until accepted.
    // ------------------------------------------------------------------
    task automatic send_rect(input t_rect r);
        while ($urandom_range(99) < src_idle_pct) begin
            rect_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rect_if.valid      <= 1'b1;
        rect_if.src_x      <= r.src_x;
        rect_if.src_y      <= r.src_y;
        rect_if.src_w      <= r.src_w;
        rect_if.src_h      <= r.src_h;
        rect_if.cont_x     <= r.cont_x;
        rect_if.cont_y     <= r.cont_y;
        rect_if.cont_w     <= r.cont_w;
        rect_if.cont_h     <= r.cont_h;
        rect_if.horz_align <= r.horz_align;
        rect_if.vert_align <= r.vert_align;
        rect_if.keep_size  <= r.keep_size;
        @(posedge i_clk);
        // Values read here are the ones the block saw at this edge
        while (!rect_if.ready) @(posedge i_clk);
        fit_expected.insert(fit_expected.size(), predict_fit(r));
    endtask

    function automatic t_rect make_rect(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                                        input logic [CB-1:0] sw, input logic [CB-1:0] sh,
                                        input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                                        input logic [CB-1:0] cw, input logic [CB-1:0] ch,
                                        input logic [1:0] ha, input logic [1:0] va,
                                        input logic keep);
        t_rect r;
        r = '{sx, sy, sw, sh, cx, cy, cw, ch, ha, va, keep};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, and the result checker
    // ------------------------------------------------------------------
    initial begin
        fit_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            fit_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : chk_fit
        t_fit want;
        if (i_rst_n && fit_if.valid && fit_if.ready) begin
            if (fit_expected.size() == 0) begin
                report_mismatch("unexpected result", 64'(fit_if.fit_x), 64'd0);
            end else begin
                want = fit_expected.pop_front();
                check_field("fit_x",    64'(fit_if.fit_x),    64'(want.fit_x));
                check_field("fit_y",    64'(fit_if.fit_y),    64'(want.fit_y));
                check_field("fit_w",    64'(fit_if.fit_w),    64'(want.fit_w));
                check_field("fit_h",    64'(fit_if.fit_h),    64'(want.fit_h));
                check_field("overhang", 64'(fit_if.overhang), 64'(want.overhang));
                check_field("bad_size", 64'(fit_if.bad_size), 64'(want.bad_size));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Drive every field to zero and to full scale.
    task automatic test_extremes();
        send_rect(make_rect('0, '0, '0, '0, '0, '0, '0, '0,
                            ALIGN_CENTER, ALIGN_CENTER, 1'b0));
        send_rect(make_rect('1, '1, '1, '1, '1, '1, '1, '1,
                            ALIGN_CENTER, ALIGN_CENTER, 1'b0));
        send_rect(make_rect('1, '1, '1, '1, '1, '1, '1, '1,
                            ALIGN_KEEP, ALIGN_KEEP, 1'b1));
        send_rect(make_rect('1, '1, '1, '1, '0, '0, '0, '0,
                            ALIGN_FAR, ALIGN_FAR, 1'b1));
    endtask

    // Pick width or height fill, including ties, truncation and zero height.
    task automatic test_fit_direction();
        send_rect(make_rect(16'd7, 16'd9, 16'd1920, 16'd1080, 16'd100, 16'd50,
                            16'd800, 16'd800, ALIGN_CENTER, ALIGN_CENTER, 1'b0));
        send_rect(make_rect(16'd7, 16'd9, 16'd300, 16'd1000, 16'd100, 16'd50,
                            16'd1000, 16'd200, ALIGN_CENTER, ALIGN_CENTER, 1'b0));
        send_rect(make_rect(16'd1, 16'd2, 16'd4, 16'd3, 16'd10, 16'd20,
                            16'd8, 16'd6, ALIGN_FAR, ALIGN_FAR, 1'b0));
        send_rect(make_rect(16'd1, 16'd2, 16'd3, 16'd7, 16'd10, 16'd20,
                            16'd10, 16'd100, ALIGN_CENTER, ALIGN_CENTER, 1'b0));
        send_rect(make_rect(16'd1, 16'd2, 16'd5, 16'd5, 16'd10, 16'd20,
                            16'd100, 16'd0, ALIGN_CENTER, ALIGN_CENTER, 1'b0));
    endtask

    // Walk every alignment code on both axes, with each fill direction.
    task automatic test_align_codes();
        for (int i = 0; i < 4; i++) begin
            send_rect(make_rect(16'd33, 16'd44, 16'd160, 16'd90, 16'd20, 16'd30,
                                16'd320, 16'd400, align_codes[i], align_codes[3 - i],
                                1'b0));
        end
        for (int i = 0; i < 4; i++) begin
            send_rect(make_rect(16'd33, 16'd44, 16'd90, 16'd160, 16'd20, 16'd30,
                                16'd400, 16'd320, align_codes[(i + 1) % 4],
                                align_codes[i], 1'b0));
        end
    endtask

    // Flag a zero-sized source when scaling, and pass it when keeping size.
    task automatic test_zero_source();
        send_rect(make_rect(16'd5, 16'd6, 16'd0, 16'd50, 16'd10, 16'd10,
                            16'd200, 16'd200, ALIGN_CENTER, ALIGN_FAR, 1'b0));
        send_rect(make_rect(16'd5, 16'd6, 16'd50, 16'd0, 16'd10, 16'd10,
                            16'd200, 16'd200, ALIGN_KEEP, ALIGN_NEAR, 1'b0));
        send_rect(make_rect(16'd5, 16'd6, 16'd0, 16'd0, 16'd10, 16'd10,
                            16'd200, 16'd200, ALIGN_FAR, ALIGN_CENTER, 1'b1));
    endtask

    // Clamp spare space on oversized sources and wrap edge sums.
    task automatic test_overhang_wrap();
        send_rect(make_rect(16'd5, 16'd6, 16'd500, 16'd20, 16'd10, 16'd10,
                            16'd100, 16'd100, ALIGN_FAR, ALIGN_CENTER, 1'b1));
        send_rect(make_rect(16'd5, 16'd6, 16'd20, 16'd500, 16'd10, 16'd10,
                            16'd100, 16'd100, ALIGN_CENTER, ALIGN_FAR, 1'b1));
        send_rect(make_rect(16'd5, 16'd6, 16'd10, 16'd10, 16'd65500, 16'd65000,
                            16'd1000, 16'd2000, ALIGN_FAR, ALIGN_CENTER, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // Random test
    // ------------------------------------------------------------------

    // Bias coordinates toward zero, full scale and small sizes.
    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return CB'($urandom_range(255));
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic test_random_fit(input int count, input int idle_pct, input int stall_pct);
        t_rect r;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            r.src_x      = CB'($urandom);
            r.src_y      = CB'($urandom);
            r.src_w      = rand_coord();
            r.src_h      = rand_coord();
            r.cont_x     = rand_coord();
            r.cont_y     = rand_coord();
            r.cont_w     = rand_coord();
            r.cont_h     = rand_coord();
            r.horz_align = align_codes[$urandom_range(3)];
            r.vert_align = align_codes[$urandom_range(3)];
            r.keep_size  = ($urandom_range(3) == 0);
            send_rect(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        mismatch_count = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        i_rst_n            <= 1'b0;
        rect_if.valid      <= 1'b0;
        rect_if.src_x      <= '0;
        rect_if.src_y      <= '0;
        rect_if.src_w      <= '0;
        rect_if.src_h      <= '0;
        rect_if.cont_x     <= '0;
        rect_if.cont_y     <= '0;
        rect_if.cont_w     <= '0;
        rect_if.cont_h     <= '0;
        rect_if.horz_align <= ALIGN_CENTER;
        rect_if.vert_align <= ALIGN_CENTER;
        rect_if.keep_size  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs with mild idling on both sides
        src_idle_pct  = 19;
        snk_stall_pct = 19;
        test_extremes();
        test_fit_direction();
        test_align_codes();
        test_zero_source();
        test_overhang_wrap();

        // Random phases: free running, sender idle, receiver stalling, both
        test_random_fit(RAND_ITEMS, 0, 0);
        test_random_fit(RAND_ITEMS, 55, 0);
        test_random_fit(RAND_ITEMS, 0, 55);
        test_random_fit(RAND_ITEMS, 19, 19);
        rect_if.valid <= 1'b0;

        // Drain, then watch a little longer for stray results
        while (fit_expected.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
src/afar_pkg.sv
src/afar_in_if.sv
src/afar_out_if.sv
src/afar_prep.sv
src/afar_div_cell.sv
src/afar_place.sv
src/aspect_fit_align_rect.sv
dv/tb.sv
